[hdl/isn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isn_pkg
// Shared constants, types and the sample conversion function.
// ----------------------------------------------------------------------------
package isn_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = 5;
    localparam int TYPES_W      = 48;
    localparam int CFG_W        = 48;

    localparam logic CFG_IDX_COUNT = 1'b0;
    localparam logic CFG_IDX_TYPES = 1'b1;

    typedef enum logic [2:0] {
        ST_I16 = 3'd0,
        ST_U16 = 3'd1,
        ST_I32 = 3'd2,
        ST_U32 = 3'd3,
        ST_F32 = 3'd4,
        ST_F64 = 3'd5,
        ST_Z6  = 3'd6,
        ST_Z7  = 3'd7
    } sample_type_t;

    typedef enum logic [1:0] {
        S_RUN   = 2'd0,
        S_READ  = 2'd1,
        S_EMIT  = 2'd2
    } emit_state_t;

    // write request into the frame store
    typedef struct packed {
        logic              en;
        logic [CH_W-1:0]   addr;
        logic [63:0]       data;
    } store_wr_t;

    function automatic logic [3:0] type_size(input logic [2:0] t);
        unique case (sample_type_t'(t))
            ST_I32, ST_U32, ST_F32: type_size = 4'd4;
            ST_F64:                 type_size = 4'd8;
            default:                type_size = 4'd2;
        endcase
    endfunction

    // leading zero count of a 32 bit magnitude, via a priority search
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    // integer magnitude m (non-zero) scaled by 2^-sc into a double
    function automatic logic [63:0] int_to_dbl(input logic s, input logic [31:0] m,
                                               input logic [10:0] sc);
        logic [5:0]  lz;
        logic [31:0] nm;
        logic [10:0] ex;
        lz = lzc32(m);
        nm = m << lz;
        ex = 11'(11'd1023 + 11'd31 - 11'(lz) - sc);
        return {s, ex, nm[30:0], 21'd0};
    endfunction

    function automatic logic [63:0] widen_f32(input logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [5:0]  lz;
        logic [31:0] nm;
        logic [10:0] ex;
        e = b[30:23];
        m = b[22:0];
        lz = lzc32({9'd0, m});
        nm = {9'd0, m} << lz;
        ex = 11'(11'd897 + 11'd8 - 11'(lz));
        if (e == 8'hff) begin
            if (m == 23'd0) return {b[31], 11'h7ff, 52'd0};
            return {b[31], 11'h7ff, 1'b1, m[21:0], 29'd0};
        end
        if (e == 8'd0) begin
            if (m == 23'd0) return {b[31], 63'd0};
            return {b[31], ex, nm[30:8], 29'd0};
        end
        return {b[31], 11'(11'(e) + 11'd896), m, 29'd0};
    endfunction

    function automatic logic [63:0] convert(input logic [2:0] t, input logic [63:0] raw);
        logic        s;
        logic [31:0] mag;
        logic [10:0] sc;
        s   = 1'b0;
        mag = 32'd0;
        sc  = 11'd15;
        unique case (sample_type_t'(t))
            ST_I16: begin
                s = raw[15];
                mag = s ? 32'(-{{16{raw[15]}}, raw[15:0]}) : {16'd0, raw[15:0]};
            end
            ST_U16: begin
                s = ~raw[15];
                mag = s ? 32'(17'h10000 - {1'b0, ~raw[15], raw[14:0]}) : {17'd0, raw[14:0]};
            end
            ST_I32: begin
                sc = 11'd31;
                s = raw[31];
                mag = s ? 32'(-raw[31:0]) : raw[31:0];
            end
            ST_U32: begin
                sc = 11'd31;
                s = ~raw[31];
                mag = s ? 32'(33'h100000000 - {1'b0, ~raw[31], raw[30:0]})
                        : {1'b0, raw[30:0]};
            end
            default: ;
        endcase
        unique case (sample_type_t'(t))
            ST_F32:       return widen_f32(raw[31:0]);
            ST_F64:       return raw;
            ST_Z6, ST_Z7: return 64'd0;
            default:      return (mag == 32'd0) ? 64'd0 : int_to_dbl(s, mag, sc);
        endcase
    endfunction

endpackage

[hdl/isn_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isn_store
// Frame sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isn_store (
    input  logic                     aclk,
    input  isn_pkg::store_wr_t       wr,
    input  logic                     rd_en,
    input  logic [isn_pkg::CH_W-1:0] rd_addr,
    output logic [63:0]              rd_data
);
    import isn_pkg::*;

    logic [63:0] mem [MAX_CHANNELS];

    always_ff @(posedge aclk) begin
        if (wr.en) mem[wr.addr] <= wr.data;
        if (rd_en) rd_data <= mem[rd_addr];
    end
endmodule

[hdl/isn_gather.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isn_gather
// Byte assembly, channel tracking and conversion into the store.
// ----------------------------------------------------------------------------
module isn_gather (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  logic [7:0]                  data_byte,
    input  logic                        start_of_buffer,
    input  logic [isn_pkg::CNT_W-1:0]   count,
    input  logic [isn_pkg::TYPES_W-1:0] types,
    output isn_pkg::store_wr_t          wr,
    output logic                        frame_done
);
    import isn_pkg::*;

    logic [63:0] gather_reg, gather_next;
    logic [2:0]  bpos_reg, bpos_next;
    logic [4:0]  cpos_reg, cpos_next;
    logic [63:0] g;
    logic [2:0]  bp;
    logic [4:0]  cp;
    logic [2:0]  t;
    logic [3:0]  size;
    logic [63:0] masked;

    always_comb begin
        g = gather_reg; bp = bpos_reg; cp = cpos_reg;
        if (start_of_buffer) begin
            g = '0; bp = '0; cp = '0;
        end
        if (cp >= count) begin
            g = '0; bp = '0; cp = '0;
        end
        g = g | (64'(data_byte) << {bp, 3'b000});
        t = types[3*cp[CH_W-1:0] +: 3];
        size = type_size(t);
        masked = g;
        if (size == 4'd2) masked = {48'd0, g[15:0]};
        else if (size == 4'd4) masked = {32'd0, g[31:0]};
        wr.en = 1'b0; wr.addr = cp[CH_W-1:0]; wr.data = convert(t, masked);
        frame_done = 1'b0;
        gather_next = gather_reg; bpos_next = bpos_reg; cpos_next = cpos_reg;
        if (take && count != '0) begin
            if (4'(bp) + 4'd1 < size) begin
                gather_next = g; bpos_next = 3'(bp + 3'd1); cpos_next = cp;
            end else begin
                wr.en = 1'b1;
                gather_next = '0; bpos_next = '0;
                cpos_next = 5'(cp + 5'd1);
                if (5'(cp + 5'd1) >= count) begin
                    frame_done = 1'b1; cpos_next = '0;
                end
            end
        end else if (take && start_of_buffer) begin
            gather_next = '0; bpos_next = '0; cpos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gather_reg <= '0; bpos_reg <= '0; cpos_reg <= '0;
        end else begin
            gather_reg <= gather_next; bpos_reg <= bpos_next; cpos_reg <= cpos_next;
        end
    end
endmodule

[hdl/interleaved_sample_normalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_sample_normalizer
// Deinterleaves little-endian PCM frames into normalised doubles.
// ----------------------------------------------------------------------------
// Usage:
//  s_ channel carries one byte per item (tdata) and start of buffer (tuser).
//  Each completed sample is converted and written to a 16 entry store in the
//  cycle its last byte is accepted. When the frame's last channel completes,
//  the frame is read back in channel order and sent on the m_ channel, one
//  item per cycle, tlast on the last channel.
//  Rate: a byte is taken every cycle while no frame is draining. A completed
//  frame holds the input while it drains: a registered store read, then one
//  item per cycle from the registered read port while the receiver accepts.
//  On a stall the output register holds and the store read waits; input
//  stays blocked until the frame's last item is in the output register.
//  Reset (aresetn low, synchronous) clears counters, gather state and config;
//  the store needs no clearing since every emitted entry is written first.
//  Config: cfg_we with cfg_addr 0 = channel_count, 1 = channel_types.
// ----------------------------------------------------------------------------
module interleaved_sample_normalizer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tuser,   // [0] start_of_buffer
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [103:0]              m_tdata,   // [3:0] channel_number,
                                                 // [35:4] frame_number,
                                                 // [99:36] sample_value, pad
    output logic                      m_tlast,   // last_of_frame
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [isn_pkg::CFG_W-1:0] cfg_wdata
);
    import isn_pkg::*;

    logic [CNT_W-1:0]   count_raw_reg;
    logic [TYPES_W-1:0] types_reg;
    logic [CNT_W-1:0]   count;
    emit_state_t        state_reg, state_next;
    logic [31:0]        frame_reg, frame_next;
    logic [4:0]         rd_idx_reg, rd_idx_next;   // next index to read
    logic [CH_W-1:0]    out_ch_reg, out_ch_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic [31:0]        out_frame_reg, out_frame_next;
    logic               take, frame_done, rd_en;
    logic [63:0]        rd_data;
    store_wr_t          wr;

    // counts above the store depth saturate
    assign count = (count_raw_reg > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                          : count_raw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_raw_reg <= '0;
            types_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_COUNT: count_raw_reg <= cfg_wdata[CNT_W-1:0];
                CFG_IDX_TYPES: types_reg     <= cfg_wdata[TYPES_W-1:0];
            endcase
        end
    end

    assign s_tready = (state_reg == S_RUN);
    assign take     = s_tvalid && s_tready;

    isn_gather u_gather (
        .aclk, .aresetn, .take,
        .data_byte(s_tdata), .start_of_buffer(s_tuser),
        .count, .types(types_reg), .wr, .frame_done
    );

    // output register may load when empty or being taken
    logic load_ok;
    assign load_ok = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_RUN:  if (take && frame_done) state_next = S_READ;
            S_READ: state_next = S_EMIT;
            S_EMIT: if (load_ok && rd_idx_reg >= count) state_next = S_RUN;
            default: state_next = S_RUN;
        endcase
    end

    always_comb begin
        rd_en = 1'b0;
        rd_idx_next = rd_idx_reg;
        frame_next = frame_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ch_next = out_ch_reg;
        out_last_next = out_last_reg;
        out_frame_next = out_frame_reg;
        if (take && s_tuser) frame_next = '0;
        unique case (state_reg)
            S_RUN: begin
                if (take && frame_done) rd_idx_next = 5'd1;
            end
            // channel 0 is read once the frame's last write has landed
            S_READ: rd_en = 1'b1;
            S_EMIT: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_ch_next    = 4'(rd_idx_reg - 5'd1);
                    out_last_next  = (rd_idx_reg >= count);
                    out_frame_next = frame_reg;
                    if (rd_idx_reg < count) begin
                        rd_en = 1'b1;
                        rd_idx_next = 5'(rd_idx_reg + 5'd1);
                    end else begin
                        frame_next = 32'(frame_reg + 32'd1);
                    end
                end
            end
            default: ;
        endcase
    end

    // read address: first read at frame end is channel 0
    logic [CH_W-1:0] rd_addr;
    assign rd_addr = (state_reg == S_EMIT) ? rd_idx_reg[CH_W-1:0] : '0;

    isn_store u_store (.aclk, .wr, .rd_en, .rd_addr, .rd_data);

    // sample value captured alongside the output register
    logic [63:0] out_val_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && load_ok) out_val_reg <= rd_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            frame_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_ch_reg    <= out_ch_next;
        out_last_reg  <= out_last_next;
        out_frame_reg <= out_frame_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_val_reg, out_frame_reg, out_ch_reg};
endmodule

[verif/tb_interleaved_sample_normalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interleaved_sample_normalizer
// Self-checking bench: a directed table of byte items, directed config cases,
// then random mixed-type frames, each checked against a behavioural model.
// ----------------------------------------------------------------------------
module tb_interleaved_sample_normalizer;
    import isn_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sob;
        logic       chk;        // directed row carries a typed-in sample
        logic [63:0] want;      // expected sample_value of the frame's channel 0
    } row_t;

    typedef struct {
        logic [3:0]  ch;
        logic [31:0] frame;
        logic [63:0] val;
        logic        last;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_IDX_COUNT;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // model state
    logic [4:0]  mdl_count;
    logic [47:0] mdl_types;
    logic [63:0] gather;
    logic [2:0]  byte_pos;
    logic [4:0]  chan_pos;
    logic [31:0] frame_ctr;
    logic [63:0] frame_store [16];

    sample_t pending_samples[$];
    int      errors = 0;
    bit      rx_hold = 1'b0;     // long receiver hold-off
    bit      rx_calm = 1'b0;     // no random stalls
    bit      tx_calm = 1'b0;

    interleaved_sample_normalizer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("interleaved_sample_normalizer test failed");
        $finish;
    end

    function automatic int bytes_of(logic [2:0] t);
        case (sample_type_t'(t))
            ST_I32, ST_U32, ST_F32: return 4;
            ST_F64: return 8;
            default: return 2;
        endcase
    endfunction

    // float32 to double, exact, quiet bit forced on NaN
    function automatic logic [63:0] f32_to_f64(logic [31:0] b);
        logic [7:0]  e;
        logic [22:0] m;
        logic [10:0] ex;
        e = b[30:23];
        m = b[22:0];
        if (e == 8'hff)
            return (m == 0) ? {b[31], 11'h7ff, 52'd0} : {b[31], 11'h7ff, 1'b1, m[21:0], 29'd0};
        if (e != 0) return {b[31], 11'(e) + 11'd896, m, 29'd0};
        if (m == 0) return {b[31], 63'd0};
        ex = 11'd897;
        while (!m[22]) begin
            m = m << 1;
            ex = ex - 1'b1;
        end
        // the leading one moves out into the hidden bit
        return {b[31], ex - 11'd1, m[21:0], 30'd0};
    endfunction

    function automatic logic [63:0] normalise(logic [2:0] t, logic [63:0] raw);
        real r;
        case (sample_type_t'(t))
            ST_I16: r = $itor($signed(raw[15:0])) / 32768.0;
            ST_U16: r = ($itor({1'b0, raw[15:0]}) - 32768.0) / 32768.0;
            ST_I32: r = $itor($signed(raw[31:0])) / 2147483648.0;
            ST_U32: r = ($itor({32'd0, raw[31:0]}) - 2147483648.0) / 2147483648.0;
            ST_F32: return f32_to_f64(raw[31:0]);
            ST_F64: return raw;
            default: return 64'd0;
        endcase
        return $realtobits(r);
    endfunction

    // advance the model by one accepted byte
    task automatic take_byte(logic [7:0] b, logic sob);
        int cnt, sz;
        logic [2:0] t;
        sample_t s;
        if (sob) begin
            gather = '0; byte_pos = '0; chan_pos = '0; frame_ctr = '0;
        end
        cnt = (mdl_count > 5'd16) ? 16 : int'(mdl_count);
        if (cnt == 0) return;
        if (chan_pos >= cnt) begin
            chan_pos = '0; byte_pos = '0; gather = '0;
        end
        gather = gather | (64'(b) << (8 * byte_pos));
        t = mdl_types[3 * chan_pos[3:0] +: 3];
        sz = bytes_of(t);
        if (byte_pos + 1 < sz) begin
            byte_pos = byte_pos + 1'b1;
            return;
        end
        if (sz < 8) gather = gather & ((64'd1 << (8 * sz)) - 64'd1);
        frame_store[chan_pos[3:0]] = normalise(t, gather);
        gather = '0; byte_pos = '0;
        chan_pos = chan_pos + 1'b1;
        if (chan_pos < cnt) return;
        for (int k = 0; k < cnt; k++) begin
            s.ch = 4'(k); s.frame = frame_ctr; s.val = frame_store[k];
            s.last = (k + 1 == cnt);
            pending_samples.push_back(s);
        end
        chan_pos = '0;
        frame_ctr = frame_ctr + 1'b1;
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_COUNT) mdl_count = v[4:0];
        else mdl_types = v[47:0];
    endtask

    // settle before a config write: drain, then cover a frame still reading out
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // offer one byte from the next falling edge; returns at the accepting rising edge
    task automatic send_byte(logic [7:0] b, logic sob);
        @(negedge aclk);
        if (!tx_calm) begin
            while ($urandom_range(99) < 22) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1; s_tdata <= b; s_tuser <= sob;
        do @(posedge aclk); while (!s_tready);
        take_byte(b, sob);
    endtask

    // random sample bytes of one channel, biased towards edge values
    task automatic send_sample(logic [2:0] t, logic sob_first);
        int sz;
        logic [63:0] v;
        sz = bytes_of(t);
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_8000_8000;
            3: v = 64'h7fff_ffff_7fff_7fff;
            4: v = {$urandom, 1'b0, 8'hff, $urandom_range(1) ? 23'd0 : 23'(1 + $urandom)};
            5: v = {$urandom, 1'b0, 8'h00, 23'($urandom)};
            default: ;
        endcase
        for (int i = 0; i < sz; i++) send_byte(v[8 * i +: 8], sob_first && i == 0);
    endtask

    // result side: random stalls, a long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= !rx_hold && (rx_calm || $urandom_range(99) >= 22);
        end
    end

    always @(posedge aclk) begin
        sample_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected sample ch %0d", m_tdata[3:0]);
                errors++;
            end else begin
                e = pending_samples.pop_front();
                if (m_tdata[3:0] !== e.ch) begin
                    $error("channel_number exp %0d got %0d", e.ch, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== e.frame) begin
                    $error("frame_number exp %0d got %0d", e.frame, m_tdata[35:4]);
                    errors++;
                end
                if (m_tdata[99:36] !== e.val) begin
                    $error("sample_value exp %h got %h", e.val, m_tdata[99:36]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_frame exp %0b got %0b", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // directed table: single channel, value read off directly; 'chk' rows
    // finish a sample, the typed value is compared to the model's result
    row_t dir_rows[9] = '{
        '{8'h00, 1'b1, 1'b0, 64'd0}, '{8'h80, 1'b0, 1'b1, 64'hBFF0_0000_0000_0000}, // i16 min -> -1.0
        '{8'h00, 1'b0, 1'b0, 64'd0}, '{8'h00, 1'b0, 1'b1, 64'd0},                   // i16 zero
        '{8'hff, 1'b0, 1'b0, 64'd0}, '{8'h7f, 1'b0, 1'b1, 64'h3FEF_FFC0_0000_0000}, // i16 max
        '{8'h12, 1'b0, 1'b0, 64'd0},                                                // partial,
        '{8'h00, 1'b1, 1'b0, 64'd0}, '{8'h40, 1'b0, 1'b1, 64'h3FE0_0000_0000_0000}  // dropped by new buffer
    };

    initial begin
        mdl_count = '0; mdl_types = '0; gather = '0; byte_pos = '0; chan_pos = '0;
        frame_ctr = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // count zero after reset: bytes swallowed
        for (int i = 0; i < 4; i++) send_byte(8'($urandom), i == 0);
        quiesce();

        write_reg(CFG_IDX_COUNT, 48'd1);
        write_reg(CFG_IDX_TYPES, {45'd0, ST_I16});
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data_byte, dir_rows[i].sob);
            if (dir_rows[i].chk) begin
                if (pending_samples.size() == 0) begin
                    $error("sample_value exp %h got none (table)", dir_rows[i].want);
                    errors++;
                end else if (pending_samples[$].val !== dir_rows[i].want) begin
                    $error("sample_value exp %h got %h (table)", dir_rows[i].want,
                           pending_samples[$].val);
                    errors++;
                end
            end
        end
        quiesce();

        // every type on its own channel, count above the maximum saturates
        write_reg(CFG_IDX_TYPES, 48'o7654321076543210);
        write_reg(CFG_IDX_COUNT, 48'd31);
        for (int c = 0; c < 16; c++) send_sample(mdl_types[3 * c +: 3], c == 0);
        quiesce();

        // count lowered mid-frame: partial frame dropped
        write_reg(CFG_IDX_COUNT, 48'd8);
        for (int c = 0; c < 5; c++) send_sample(mdl_types[3 * c +: 3], 1'b0);
        quiesce();
        write_reg(CFG_IDX_COUNT, 48'd3);
        // type changed mid-sample: f64 channel re-typed to i16 after one byte
        write_reg(CFG_IDX_TYPES, {39'd0, ST_U16, ST_I32, ST_F64});
        send_byte(8'hA5, 1'b0);
        quiesce();
        write_reg(CFG_IDX_TYPES, {39'd0, ST_U16, ST_I32, ST_I16});
        for (int c = 0; c < 4; c++) send_sample(mdl_types[3 * (c % 3) +: 3], 1'b0);
        quiesce();

        // random phases: well-formed frames, occasional restarts and noise
        for (int ph = 0; ph < 8; ph++) begin
            int n_items;
            write_reg(CFG_IDX_COUNT, (ph == 0) ? 48'd16 : (ph == 1) ? 48'd1
                                                       : 48'($urandom_range(1, 6)));
            write_reg(CFG_IDX_TYPES, 48'({$urandom, $urandom}));
            tx_calm = (ph == 2);
            rx_calm = (ph == 2);
            if (ph == 3) begin
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(negedge aclk);
                        rx_hold = 1'b0;
                    end
                join_none
            end
            n_items = 0;
            while (n_items < 20) begin
                for (int c = 0; c < ((mdl_count > 16) ? 16 : mdl_count); c++) begin
                    send_sample(mdl_types[3 * c +: 3], c == 0 && $urandom_range(9) == 0);
                    n_items += bytes_of(mdl_types[3 * c +: 3]);
                end
                if ($urandom_range(9) == 0) begin
                    send_byte(8'($urandom), 1'b1);   // broken frame
                    n_items++;
                end
            end
            // sender pauses until all results are back
            if (ph == 4) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (pending_samples.size() != 0) @(negedge aclk);
            end
            quiesce();
        end
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        quiesce();

        if (errors == 0)
            $display("interleaved_sample_normalizer test passed");
        else
            $display("interleaved_sample_normalizer test failed");
        $finish;
    end

endmodule
